[hw/rtl/bphd_pkg.sv]
// Package for the button press/hold detector.
// Types, register indexes and reset constants shared by all bphd modules.
// No dependencies.
package bphd_pkg;

  localparam int unsigned TickW   = 16;
  localparam int unsigned CountW  = 32;
  localparam int unsigned PhaseW  = 2;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [TickW-1:0] DebounceRst = TickW'(50);
  localparam logic [TickW-1:0] HoldRst     = TickW'(1000);
  localparam logic [TickW-1:0] TickMax     = '1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEBOUNCE = 2'd0,
    CFG_HOLD     = 2'd1
  } cfg_idx_e;

  // Reported phase codes
  localparam logic [PhaseW-1:0] PhaseIdle    = 2'd0;
  localparam logic [PhaseW-1:0] PhasePressed = 2'd1;
  localparam logic [PhaseW-1:0] PhaseHolding = 2'd2;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'b001,
    MODE_PRESSED = 3'b010,
    MODE_HOLDING = 3'b100
  } mode_e;

  typedef struct packed {
    logic              pushed;
    logic              hold;
    logic              released;
    logic [CountW-1:0] event_count;
    logic [PhaseW-1:0] phase;
  } result_t;

endpackage

[hw/rtl/button_press_hold_detector_unit.sv]
// Top level of the button press/hold detector.
// Instantiates bphd_in_stage, bphd_core and bphd_out_stage; depends on bphd_pkg.

// One transaction per sampled button level, one result transaction per input.
// Throughput is one transaction per clock unless out_ready_i stalls; a sample
// passes the input register, then the state update into the result register.
// The user writes thresholds through the cfg port only while no transaction is
// in flight (unchecked); indexes 0/1 set debounce/hold length, others ignored.
module button_press_hold_detector_unit import bphd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [TickW-1:0]   cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               button_down_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               pushed_event_o,
  output logic               hold_event_o,
  output logic               released_event_o,
  output logic [CountW-1:0]  event_count_o,
  output logic [PhaseW-1:0]  phase_o
);

  logic    s1_valid, s1_down, out_free, step;
  result_t core_res, out_res;

  assign step = s1_valid && out_free;

  bphd_in_stage u_in (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .button_down_i,
    .advance_i  (out_free),
    .s1_valid_o (s1_valid),
    .s1_down_o  (s1_down)
  );

  bphd_core u_core (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_data_i,
    .step_i   (step),
    .down_i   (s1_down),
    .result_o (core_res)
  );

  bphd_out_stage u_out (
    .clk_i,
    .rst_ni,
    .load_i      (step),
    .result_i    (core_res),
    .out_ready_i,
    .out_valid_o,
    .free_o      (out_free),
    .result_o    (out_res)
  );

  assign pushed_event_o   = out_res.pushed;
  assign hold_event_o     = out_res.hold;
  assign released_event_o = out_res.released;
  assign event_count_o    = out_res.event_count;
  assign phase_o          = out_res.phase;

endmodule

[hw/rtl/bphd_in_stage.sv]
// Input register of the button press/hold detector.
// Holds one sampled button level; depends on bphd_pkg.
module bphd_in_stage import bphd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic button_down_i,
  input  logic advance_i,
  output logic s1_valid_o,
  output logic s1_down_o
);

  logic valid_q, valid_d;
  logic down_q;

  // refill in the same cycle the held transaction moves on
  assign in_ready_o = !valid_q || advance_i;
  assign valid_d    = (in_valid_i && in_ready_o) || (valid_q && !advance_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      down_q <= button_down_i;
    end
  end

  assign s1_valid_o = valid_q;
  assign s1_down_o  = down_q;

endmodule

[hw/rtl/bphd_core.sv]
// State update of the button press/hold detector: thresholds, tick counter,
// mode and event count. Depends on bphd_pkg.
module bphd_core import bphd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [TickW-1:0]   cfg_data_i,
  input  logic               step_i,
  input  logic               down_i,
  output result_t            result_o
);

  logic [TickW-1:0]  debounce_q, hold_q;
  logic [TickW-1:0]  tick_q, tick_d, tick_inc;
  mode_e             mode_q, mode_d;
  logic [CountW-1:0] count_q, count_d;
  logic              pushed, hold, released;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DebounceRst;
      hold_q     <= HoldRst;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_DEBOUNCE) begin
        debounce_q <= cfg_data_i;
      end else if (cfg_index_i == CFG_HOLD) begin
        hold_q <= cfg_data_i;
      end
    end
  end

  // saturating tick count
  assign tick_inc = (tick_q != TickMax) ? tick_q + TickW'(1) : tick_q;

  always_comb begin
    tick_d   = tick_q;
    mode_d   = mode_q;
    count_d  = count_q;
    pushed   = 1'b0;
    hold     = 1'b0;
    released = 1'b0;
    if (down_i) begin
      tick_d = tick_inc;
      case (mode_q)
        MODE_IDLE: begin
          if (tick_inc >= debounce_q) begin
            count_d = count_q + CountW'(1);
            tick_d  = '0;
            mode_d  = MODE_PRESSED;
            pushed  = 1'b1;
          end
        end
        MODE_PRESSED: begin
          if (tick_inc >= hold_q) begin
            count_d = count_q + CountW'(1);
            tick_d  = '0;
            mode_d  = MODE_HOLDING;
            hold    = 1'b1;
          end
        end
        MODE_HOLDING: begin
          tick_d = tick_inc;
        end
        default: begin
          tick_d = tick_inc;
        end
      endcase
    end else begin
      released = (mode_q == MODE_HOLDING);
      tick_d   = '0;
      mode_d   = MODE_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q  <= '0;
      mode_q  <= MODE_IDLE;
      count_q <= '0;
    end else if (step_i) begin
      tick_q  <= tick_d;
      mode_q  <= mode_d;
      count_q <= count_d;
    end
  end

  always_comb begin
    result_o.pushed      = pushed;
    result_o.hold        = hold;
    result_o.released    = released;
    result_o.event_count = count_d;
    case (mode_d)
      MODE_IDLE:    result_o.phase = PhaseIdle;
      MODE_PRESSED: result_o.phase = PhasePressed;
      MODE_HOLDING: result_o.phase = PhaseHolding;
      default:      result_o.phase = PhaseIdle;
    endcase
  end

endmodule

[hw/rtl/bphd_out_stage.sv]
// Result register of the button press/hold detector.
// Holds one result until the consumer takes it; depends on bphd_pkg.
module bphd_out_stage import bphd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t result_i,
  input  logic    out_ready_i,
  output logic    out_valid_o,
  output logic    free_o,
  output result_t result_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  assign free_o  = !valid_q || out_ready_i;
  assign valid_d = load_i || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = res_q;

endmodule
